FILE: sv/bsim_pkg.sv
// types and constants shared by the bank-switch / irq mapper modules
// no dependencies

package bsim_pkg;

  localparam int CntW = 18;

  // request kinds
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_CYCLE = 2'd1;
  localparam logic [1:0] REQ_LINE  = 2'd2;

  // register addresses
  localparam logic [15:0] ADDR_PRG0    = 16'h8000;
  localparam logic [15:0] ADDR_PRG1    = 16'hA000;
  localparam logic [15:0] ADDR_PRG2    = 16'hC000;
  localparam logic [15:0] ADDR_CHR     = 16'hB000;
  localparam logic [15:0] ADDR_CHR_MSK = 16'hFFF8;
  localparam logic [15:0] ADDR_MIR_STD = 16'h9000;
  localparam logic [15:0] ADDR_MIR_ALT = 16'h9001;
  localparam logic [15:0] ADDR_IRQ_CTL = 16'h9003;
  localparam logic [15:0] ADDR_IRQ_LD  = 16'h9004;
  localparam logic [15:0] ADDR_IRQ_HI  = 16'h9005;
  localparam logic [15:0] ADDR_IRQ_LO  = 16'h9006;

  localparam logic [2:0] PRG_SLOT0 = 3'd0;
  localparam logic [2:0] PRG_SLOT1 = 3'd1;
  localparam logic [2:0] PRG_SLOT2 = 3'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRG,
    OP_CHR,
    OP_MIRROR,
    OP_IRQ_CTL,
    OP_IRQ_LOAD,
    OP_RELOAD_HI,
    OP_RELOAD_LO,
    OP_ALT_LOAD,
    OP_ALT_EN,
    OP_CYC_TICK,
    OP_LINE_TICK
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] slot;
    logic [7:0] value;
  } bsim_op_t;

  typedef struct packed {
    logic       irq_line;
    logic       mirroring;
    logic       prg_update;
    logic [1:0] prg_slot;
    logic [7:0] prg_bank;
    logic       chr_update;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
  } bsim_result_t;

endpackage

FILE: sv/bsim_if.sv
// valid/ready channel interfaces for request and result beats
// no dependencies

interface bsim_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [15:0] address;
  logic [7:0] data;
  logic [7:0] cycle_count;

  modport source (output valid, req_type, address, data, cycle_count, input ready);
  modport sink (input valid, req_type, address, data, cycle_count, output ready);
endinterface

interface bsim_res_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic       mirroring;
  logic       prg_update;
  logic [1:0] prg_slot;
  logic [7:0] prg_bank;
  logic       chr_update;
  logic [2:0] chr_slot;
  logic [7:0] chr_bank;

  modport source (output valid, irq_line, mirroring, prg_update, prg_slot, prg_bank,
                  chr_update, chr_slot, chr_bank, input ready);
  modport sink (input valid, irq_line, mirroring, prg_update, prg_slot, prg_bank,
                chr_update, chr_slot, chr_bank, output ready);
endinterface

FILE: sv/bsim_front.sv
// front end: classifies a request beat into one back-end operation
// depends on bsim_pkg

module bsim_front
  import bsim_pkg::*;
(
  input  logic        alt_mode,
  input  logic [1:0]  req_type,
  input  logic [15:0] address,
  input  logic [7:0]  data,
  input  logic [7:0]  cycle_count,
  output bsim_op_t    op
);

  always_comb begin
    op.op    = OP_NONE;
    op.slot  = '0;
    op.value = data;
    unique case (req_type)
      REQ_WRITE: begin
        if (address == ADDR_PRG0) begin
          op.op   = OP_PRG;
          op.slot = PRG_SLOT0;
        end else if (address == ADDR_PRG1) begin
          op.op   = OP_PRG;
          op.slot = PRG_SLOT1;
        end else if (address == ADDR_PRG2) begin
          op.op   = OP_PRG;
          op.slot = PRG_SLOT2;
        end else if ((address & ADDR_CHR_MSK) == ADDR_CHR) begin
          op.op   = OP_CHR;
          op.slot = address[2:0];
        end else if (!alt_mode) begin
          if (address == ADDR_MIR_STD) begin
            op.op    = OP_MIRROR;
            op.value = {7'd0, data[6]};
          end else if (address == ADDR_IRQ_CTL) begin
            op.op = OP_IRQ_CTL;
          end else if (address == ADDR_IRQ_LD) begin
            op.op = OP_IRQ_LOAD;
          end else if (address == ADDR_IRQ_HI) begin
            op.op = OP_RELOAD_HI;
          end else if (address == ADDR_IRQ_LO) begin
            op.op = OP_RELOAD_LO;
          end
        end else begin
          if (address == ADDR_MIR_ALT) begin
            op.op    = OP_MIRROR;
            op.value = {7'd0, data[7]};
          end else if (address == ADDR_IRQ_HI) begin
            op.op = OP_ALT_LOAD;
          end else if (address == ADDR_IRQ_LO) begin
            op.op = OP_ALT_EN;
          end
        end
      end
      REQ_CYCLE: begin
        if (!alt_mode) begin
          op.op    = OP_CYC_TICK;
          op.value = cycle_count;
        end
      end
      REQ_LINE: begin
        if (alt_mode) op.op = OP_LINE_TICK;
      end
      default: op.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/bsim_fifo.sv
// small operation queue between front and back, one push and one pop per cycle
// depends on bsim_pkg

module bsim_fifo
  import bsim_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bsim_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output bsim_op_t head_op
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  bsim_op_t          mem [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: sv/bsim_back.sv
// back end: irq counter, latch, mirroring state and the result register
// depends on bsim_pkg

module bsim_back
  import bsim_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  bsim_op_t     in_op,
  output logic         in_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output bsim_result_t out_res
);

  logic            irq_enabled, irq_enabled_next;
  logic [CntW-1:0] irq_count, irq_count_next;
  logic [15:0]     reload_value, reload_value_next;
  logic            irq_level, irq_level_next;
  logic            mirror_bit, mirror_bit_next;
  bsim_result_t    res_next;
  logic            cnt_expired;

  assign in_pop      = in_valid && (!out_valid || out_ready);
  assign cnt_expired = (irq_count == '0) || irq_count[CntW-1];

  always_comb begin
    irq_enabled_next  = irq_enabled;
    irq_count_next    = irq_count;
    reload_value_next = reload_value;
    irq_level_next    = irq_level;
    mirror_bit_next   = mirror_bit;
    res_next          = '0;
    case (in_op.op)
      OP_PRG: begin
        res_next.prg_update = 1'b1;
        res_next.prg_slot   = in_op.slot[1:0];
        res_next.prg_bank   = in_op.value;
      end
      OP_CHR: begin
        res_next.chr_update = 1'b1;
        res_next.chr_slot   = in_op.slot;
        res_next.chr_bank   = in_op.value;
      end
      OP_MIRROR: mirror_bit_next = in_op.value[0];
      OP_IRQ_CTL: begin
        irq_enabled_next = in_op.value[7];
        irq_level_next   = 1'b0;
      end
      OP_IRQ_LOAD:  irq_count_next = {2'b00, reload_value};
      OP_RELOAD_HI: reload_value_next = {in_op.value, reload_value[7:0]};
      OP_RELOAD_LO: reload_value_next = {reload_value[15:8], in_op.value};
      OP_ALT_LOAD: begin
        irq_count_next   = {9'd0, in_op.value, 1'b0};
        irq_enabled_next = (in_op.value != '0);
        irq_level_next   = 1'b0;
      end
      OP_ALT_EN: irq_enabled_next = 1'b1;
      OP_CYC_TICK: begin
        if (irq_enabled) begin
          if (cnt_expired) irq_level_next = 1'b1;
          else irq_count_next = irq_count - {10'd0, in_op.value};
        end
      end
      OP_LINE_TICK: begin
        if (irq_enabled) begin
          if (irq_count == '0) irq_level_next = 1'b1;
          else irq_count_next = irq_count - 1'b1;
        end
      end
      default: ;
    endcase
    res_next.irq_line  = irq_level_next;
    res_next.mirroring = mirror_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enabled  <= 1'b0;
      irq_count    <= '0;
      reload_value <= '0;
      irq_level    <= 1'b0;
      mirror_bit   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (in_pop) begin
        irq_enabled  <= irq_enabled_next;
        irq_count    <= irq_count_next;
        reload_value <= reload_value_next;
        irq_level    <= irq_level_next;
        mirror_bit   <= mirror_bit_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) out_res <= res_next;
  end

endmodule

FILE: sv/bank_switch_irq_mapper.sv
// bank-switch and irq unit: one result beat per request beat, registered in the back end
// throughput one beat per clock while results are taken, each beat updating the counter state
// at full rate the queue holds one beat, so its other QUEUE_DEPTH - 1 entries absorb result stalls
// synchronous reset clears counter, latch, enables, mirroring, mode and the queue
// depends on bsim_pkg, bsim_if, bsim_front, bsim_fifo, bsim_back

module bank_switch_irq_mapper
  import bsim_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_data,
  bsim_cmd_if.sink   cmd,
  bsim_res_if.source res
);

  logic         alt_mode;
  bsim_op_t     dec_op;
  bsim_op_t     head_op;
  logic         q_full;
  logic         head_valid;
  logic         pop;
  logic         push;
  bsim_result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) alt_mode <= 1'b0;
    else if (cfg_we) alt_mode <= cfg_data;
  end

  assign cmd.ready = !q_full;
  assign push      = cmd.valid && !q_full;

  bsim_front u_front (
    .alt_mode    (alt_mode),
    .req_type    (cmd.req_type),
    .address     (cmd.address),
    .data        (cmd.data),
    .cycle_count (cmd.cycle_count),
    .op          (dec_op)
  );

  bsim_fifo #(.Depth(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (dec_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  bsim_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (head_valid),
    .in_op     (head_op),
    .in_pop    (pop),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.irq_line   = out_res.irq_line;
  assign res.mirroring  = out_res.mirroring;
  assign res.prg_update = out_res.prg_update;
  assign res.prg_slot   = out_res.prg_slot;
  assign res.prg_bank   = out_res.prg_bank;
  assign res.chr_update = out_res.chr_update;
  assign res.chr_slot   = out_res.chr_slot;
  assign res.chr_bank   = out_res.chr_bank;

  // a full queue only builds up behind a stalled result
  a_full_means_stall: assert property (@(posedge clk) disable iff (rst)
    q_full |-> res.valid)
    else $error("queue full without a pending result");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.prg_update && res.chr_update))
    else $error("program and pattern update in one beat");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.prg_update) |-> (res.prg_bank == '0 && res.prg_slot == '0))
    else $error("program fields set without update");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result valid right after reset");

endmodule
